// File: hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Command codes, status codes, payload structs and front-to-back job record.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned DEF_WIDTH = 32;
  localparam int unsigned MAG_W     = 64;  // products: 32x32 magnitudes
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    CMD_NORM = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_CMP  = 3'd5,
    CMD_NEG  = 3'd6,
    CMD_NONE = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2,
    ORD_RSVD    = 2'd3
  } order_t;

  typedef struct packed {
    logic [2:0]  command;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic [30:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  order;
    logic [1:0]  status;
  } out_item_t;

  // classified job handed from front to back
  typedef struct packed {
    logic        direct;   // result known already, no reduction needed
    out_item_t   res;      // result when direct
    logic        neg;      // sign of reduced fraction
    logic [31:0] ma;       // |a_num|
    logic [31:0] mad;      // |a_den|
    logic [31:0] mb;       // |b_num|
    logic [30:0] bd;
    logic [2:0]  command;
    logic        sa;
    logic        sb;
  } job_t;

endpackage

// File: hdl/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front: input stage
// Accepts items, splits signs from magnitudes and sorts out error and trivial
// commands; writes one job record per item into the queue.
// ----------------------------------------------------------------------------
module rau_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  rau_pkg::in_item_t item,
  output logic              job_valid,
  input  logic              job_stall,
  output rau_pkg::job_t     job
);
  import rau_pkg::*;

  job_t job_c;
  logic sa, sad, sb;

  always_comb begin
    sa  = item.a_num[31];
    sad = item.a_den[31];
    sb  = item.b_num[31];
    job_c = '0;
    job_c.command = item.command;
    job_c.ma  = sa  ? 32'(-item.a_num) : item.a_num;
    job_c.mad = sad ? 32'(-item.a_den) : item.a_den;
    job_c.mb  = sb  ? 32'(-item.b_num) : item.b_num;
    job_c.bd  = item.b_den;
    job_c.sa  = (sa ^ sad) && (job_c.ma != '0);
    job_c.sb  = sb && (job_c.mb != '0);
    job_c.res.res_num = '0;
    job_c.res.res_den = 31'd1;
    job_c.res.order   = ORD_LESS;
    job_c.res.status  = ST_OK;
    job_c.direct = 1'b1;
    if (cmd_t'(item.command) == CMD_NONE) begin
      job_c.direct = 1'b1;
    end else if (job_c.mad == '0 || (item.command >= CMD_ADD && item.command <= CMD_CMP
                 && item.b_den == '0)) begin
      job_c.res.status = ST_ZERO;
    end else if (cmd_t'(item.command) == CMD_DIV && job_c.mb == '0) begin
      job_c.res.status = ST_ZERO;
    end else begin
      job_c.direct = 1'b0;
    end
  end

  // one-entry output register
  assign stall = job_valid && job_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (!stall) begin
      job_valid <= valid;
    end
    if (!stall && valid) begin
      job <= job_c;
    end
  end

endmodule

// File: hdl/rau_queue.sv
// ----------------------------------------------------------------------------
// rau_queue: small FIFO between front and back
// Register-based queue; stall when full.
// ----------------------------------------------------------------------------
module rau_queue #(
  parameter int unsigned DEPTH = rau_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rau_pkg::job_t in_job,
  output logic          out_valid,
  input  logic          out_stall,
  output rau_pkg::job_t out_job
);
  import rau_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic push, pop;

  assign in_stall  = (count == (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign push = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;
  assign out_job = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) begin
      mem[wptr] <= in_job;
    end
  end

endmodule

// File: hdl/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back: execution sequencer
// Forms products with one shared 32x32 multiplier, runs a binary gcd over the
// 64-bit numerator and denominator, then reduces both by restoring division.
// ----------------------------------------------------------------------------
module rau_back #(
  parameter int unsigned WIDTH = rau_pkg::DEF_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_stall,
  input  rau_pkg::job_t      job,
  output logic               valid,
  input  logic               stall,
  output rau_pkg::out_item_t item
);
  import rau_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL1 = 9'b000000010,
    S_MUL2 = 9'b000000100,
    S_MUL3 = 9'b000001000,
    S_COMB = 9'b000010000,
    S_GCD  = 9'b000100000,
    S_DIVN = 9'b001000000,
    S_DIVD = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  localparam logic [MAG_W-1:0] LIMIT = MAG_W'(1) << (WIDTH-1);

  state_t state, state_next;
  job_t   cur;
  out_item_t res;                  // result fields known before reduction
  logic [MAG_W-1:0] p, q;          // products
  logic [MAG_W-1:0] nm, dm;        // fraction being reduced
  logic [MAG_W-1:0] gx, gy;        // gcd operands
  logic [5:0]       gshift;
  logic [MAG_W-1:0] quo, rem;      // divider
  logic [6:0]       dcnt;
  logic [MAG_W-1:0] g;
  logic             neg;
  logic [31:0]      mx, my;
  logic [MAG_W-1:0] prod;
  logic [MAG_W:0]   rem_sh;
  logic             div_ge;
  logic [MAG_W-1:0] rem_nx, quo_nx;
  logic [MAG_W-1:0] nm_c, dm_c;
  logic             neg_c;
  order_t           ord_c;
  logic             ovf;
  logic             from_div;
  out_item_t        red;

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_MUL1: begin
        mx = cur.ma;
        my = {1'b0, cur.bd};
      end
      S_MUL2: begin
        mx = (cmd_t'(cur.command) == CMD_MUL) ? cur.ma : cur.mb;
        my = (cmd_t'(cur.command) == CMD_MUL) ? cur.mb : cur.mad;
      end
      S_MUL3: begin
        mx = cur.mad;
        my = (cmd_t'(cur.command) == CMD_DIV) ? cur.mb : {1'b0, cur.bd};
      end
      default: begin
        mx = cur.ma;
        my = 32'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= MAG_W'(mx) * MAG_W'(my);
  end

  assign job_stall = (state != S_IDLE);

  // restoring divider step
  assign rem_sh = {rem, quo[MAG_W-1]};
  assign div_ge = (rem_sh >= {1'b0, g});
  assign rem_nx = div_ge ? MAG_W'(rem_sh - {1'b0, g}) : rem_sh[MAG_W-1:0];
  assign quo_nx = {quo[MAG_W-2:0], div_ge};

  // in S_COMB: p = ma*bd, q = mb*mad (ma*mb for multiply), prod = third product
  always_comb begin
    nm_c  = '0;
    dm_c  = prod;
    neg_c = 1'b0;
    ord_c = ORD_LESS;
    unique case (cmd_t'(cur.command))
      CMD_NORM, CMD_NEG: begin
        nm_c  = MAG_W'(cur.ma);
        dm_c  = MAG_W'(cur.mad);
        neg_c = (cmd_t'(cur.command) == CMD_NEG) ? (!cur.sa && cur.ma != '0) : cur.sa;
      end
      CMD_MUL: begin
        nm_c  = q;
        neg_c = cur.sa != cur.sb;
      end
      CMD_DIV: begin
        nm_c  = p;
        neg_c = cur.sa != cur.sb;
      end
      CMD_ADD, CMD_SUB: begin
        if (cur.sa == (cur.sb ^ (cmd_t'(cur.command) == CMD_SUB && cur.mb != '0))) begin
          nm_c  = p + q;
          neg_c = cur.sa;
        end else if (p >= q) begin
          nm_c  = p - q;
          neg_c = cur.sa;
        end else begin
          nm_c  = q - p;
          neg_c = !cur.sa;
        end
      end
      CMD_CMP: begin
        if (cur.sa != cur.sb) ord_c = cur.sa ? ORD_LESS : ORD_GREATER;
        else if (p == q) ord_c = ORD_EQUAL;
        else if (!cur.sa) ord_c = (p < q) ? ORD_LESS : ORD_GREATER;
        else ord_c = (p > q) ? ORD_LESS : ORD_GREATER;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (job_valid) state_next = job.direct ? S_DONE : S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_MUL3;
      S_MUL3: state_next = S_COMB;
      S_COMB: state_next = (cmd_t'(cur.command) == CMD_CMP) ? S_DONE : S_GCD;
      S_GCD:  if (gy == '0 || gx == '0) state_next = S_DIVN;
      S_DIVN: if (dcnt == 7'd0) state_next = S_DIVD;
      S_DIVD: if (dcnt == 7'd0) state_next = S_DONE;
      S_DONE: if (!stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign valid = (state == S_DONE);
  assign ovf = (dm > LIMIT - 64'd1) || (neg ? (nm > LIMIT) : (nm > LIMIT - 64'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    unique case (state)
      S_IDLE: begin
        if (job_valid) begin
          cur <= job;
          res <= job.res;
        end
      end
      S_MUL1: ;
      S_MUL2: p <= prod;
      S_MUL3: q <= prod;
      S_COMB: begin
        nm        <= nm_c;
        dm        <= dm_c;
        neg       <= neg_c;
        gx        <= nm_c;
        gy        <= dm_c;
        gshift    <= '0;
        res.order <= ord_c;
      end
      S_GCD: begin
        // binary gcd, one step a cycle
        if (gx == '0 || gy == '0) begin
          g    <= (gx | gy) << gshift;
          quo  <= nm;
          rem  <= '0;
          dcnt <= 7'd63;
        end else if (!gx[0] && !gy[0]) begin
          gx     <= gx >> 1;
          gy     <= gy >> 1;
          gshift <= gshift + 6'd1;
        end else if (!gx[0]) begin
          gx <= gx >> 1;
        end else if (!gy[0]) begin
          gy <= gy >> 1;
        end else if (gx >= gy) begin
          gx <= (gx - gy) >> 1;
        end else begin
          gy <= (gy - gx) >> 1;
        end
      end
      S_DIVN, S_DIVD: begin
        if (dcnt != 7'd0) begin
          rem  <= rem_nx;
          quo  <= quo_nx;
          dcnt <= dcnt - 7'd1;
        end else if (state == S_DIVN) begin
          nm   <= quo_nx;
          quo  <= dm;
          rem  <= '0;
          dcnt <= 7'd63;
        end else begin
          dm <= quo_nx;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // output fields once reduced (nm, dm final in S_DONE after the divider)
  always_ff @(posedge clk) begin
    if (rst) from_div <= 1'b0;
    else if (state == S_DIVD && dcnt == 7'd0) from_div <= 1'b1;
    else if (state == S_IDLE) from_div <= 1'b0;
  end

  always_comb begin
    red = res;
    if (from_div) begin
      red.order = ORD_LESS;
      if (ovf) begin
        red.res_num = '0;
        red.res_den = 31'd1;
        red.status  = ST_OVF;
      end else begin
        red.res_num = (neg && nm != '0) ? 32'(-nm) : nm[31:0];
        red.res_den = dm[30:0];
        red.status  = ST_OK;
      end
    end
  end

  assign item = red;

endmodule

// File: hdl/rational_arithmetic_unit.sv
// Errors and command 7 go straight to the result; compare ends after the three
// products; fraction results take three products from the shared multiplier, a
// binary gcd and then two 64-step restoring divisions.
// The back sequencer works on one item at a time; it takes the next job in the
// cycle after each result transfer while the front and a 2-entry queue buffer input.
// Reset (rst, synchronous) empties the queue and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: gcd-reduced rational number ALU
// Front classifier, job queue and iterative back end.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = rau_pkg::DEF_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rau_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output rau_pkg::out_item_t out_item
);
  import rau_pkg::*;

  logic f_valid, f_stall, q_valid, q_stall;
  job_t f_job, q_job;
  out_item_t b_item;

  rau_front u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .item(in_item),
    .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
  );

  rau_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .in_valid(f_valid), .in_stall(f_stall), .in_job(f_job),
    .out_valid(q_valid), .out_stall(q_stall), .out_job(q_job)
  );

  rau_back #(.WIDTH(WIDTH)) u_back (
    .clk, .rst, .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
    .valid(out_valid), .stall(out_stall), .item(b_item)
  );

  assign out_item = b_item;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped under stall");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.status != ST_RSVD) else $error("bad status");
  a_den: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.res_den != '0) else $error("zero denominator out");
`endif

endmodule
